/* sv/cbr_pkg.sv */
// shared constants, types and state codes of the channel busy ratio meter
package cbr_pkg;

    // node table
    localparam int NODE_W = 6;
    localparam int NODES = 1 << NODE_W;

    // field widths
    localparam int FUNC_W = 2;
    localparam int TIME_W = 48;
    localparam int ACC_W = 40;
    localparam int WMS_W = 14;
    localparam int ALPHA_W = 17;
    localparam int RATIO_W = 17;

    // input tdata layout, lowest field first
    localparam int NODE_LSB = 0;
    localparam int START_LSB = NODE_LSB + NODE_W;
    localparam int DUR_LSB = START_LSB + TIME_W;
    localparam int BUSY_LSB = DUR_LSB + ACC_W;
    localparam int NOW_LSB = BUSY_LSB + 1;
    localparam int IN_FIELDS_W = NOW_LSB + TIME_W;
    localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RATIO_W + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = ALPHA_W;
    localparam logic [WMS_W-1:0] WMS_RESET = WMS_W'(100);
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(32768);

    // fixed point
    localparam logic [RATIO_W-1:0] ONE_Q16 = RATIO_W'(65536);
    localparam int NS_PER_MS_W = 20;
    localparam logic [NS_PER_MS_W-1:0] NS_PER_MS = NS_PER_MS_W'(1000000);
    localparam int WNS_W = WMS_W + NS_PER_MS_W;

    // mean over the table and the shared divider
    localparam int SUM_W = RATIO_W + NODE_W;
    localparam int CNT_W = NODE_W + 1;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] TICK_STEPS = STEP_W'(16);
    localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(SUM_W);

    typedef enum logic [FUNC_W-1:0] {
        FN_EVENT     = 2'd0,
        FN_TICK      = 2'd1,
        FN_READ_NODE = 2'd2,
        FN_READ_MEAN = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_MS = 1'b0,
        REG_ALPHA     = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EV_RD,
        ST_EV_WR,
        ST_TK_RD,
        ST_TK_CALC,
        ST_TK_DIV,
        ST_TK_EMA,
        ST_TK_END,
        ST_QR_RD,
        ST_QR_GET,
        ST_MN_RD,
        ST_MN_ACC,
        ST_MN_START,
        ST_MN_DIV,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [WNS_W-1:0]  rem0;
        logic [SUM_W-1:0]  ext;
        logic [WNS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quot;
    } div_rsp_t;

endpackage

/* sv/cbr_ram.sv */
// generic single write port, single read port memory with registered read data
module cbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/cbr_div.sv */
// restoring divider, one quotient bit per cycle, shared by tick ratio and table mean
module cbr_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cbr_pkg::div_req_t req,
    output cbr_pkg::div_rsp_t rsp
);

    logic                        busy_reg;
    logic                        done_reg;
    logic [cbr_pkg::STEP_W-1:0]  cnt_reg;
    logic [cbr_pkg::WNS_W-1:0]   rem_reg;
    logic [cbr_pkg::SUM_W-1:0]   ext_reg;
    logic [cbr_pkg::SUM_W-1:0]   quot_reg;
    logic [cbr_pkg::WNS_W-1:0]   divisor_reg;

    logic [cbr_pkg::WNS_W:0]     trial;
    logic                        fits;
    logic [cbr_pkg::WNS_W:0]     diff;
    logic [cbr_pkg::WNS_W-1:0]   rem_next;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, ext_reg[cbr_pkg::SUM_W-1]};
    assign fits = (trial >= {1'b0, divisor_reg});
    assign diff = trial - {1'b0, divisor_reg};
    assign rem_next = fits ? diff[cbr_pkg::WNS_W-1:0] : trial[cbr_pkg::WNS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == cbr_pkg::STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - cbr_pkg::STEP_W'(1);
                if (cnt_reg == cbr_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.rem0;
            ext_reg     <= req.ext;
            divisor_reg <= req.divisor;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            ext_reg  <= {ext_reg[cbr_pkg::SUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[cbr_pkg::SUM_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

/* sv/channel_busy_ratio_meter_unit.sv */
// top level of the channel busy ratio meter: sequencer, node tables and result register
//
//  channel   direction  fields (lowest bit first)                         transfer when
//  s_axis    in         tuser: func; tdata: node, start_ns, duration_ns,  tvalid & tready
//                       busy_req, now_ns, zero pad
//  m_axis    out        tuser: valid_res; tdata: ratio, zero pad          tvalid & tready
//  cfg       in         cfg_addr: register, cfg_wdata: value              cfg_we
//
// one item is worked at a time; the sequencer and its memory round trips set the rate
// phy event and node read: a memory read, then the write or fetch, then the result register
// window tick: a read per node, plus a run of the 16-step divider per seen node whose
//   busy time stays below a full window; a seen node at a full window skips the divider
// overall read: a read and an accumulate per node, then a 23-step divide;
//   no divide when no node holds an average
// reset clears control, seen and average flags; the node memories need no clearing pass
// a new item is taken while a finished result still waits on m_axis
module channel_busy_ratio_meter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // tdata: node, start_ns, duration_ns, busy_req, now_ns, pad
    input  logic [cbr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: func
    input  logic [cbr_pkg::FUNC_W-1:0]        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: ratio, pad
    output logic [cbr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: valid_res
    output logic                              m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_we,
    input  logic [cbr_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [cbr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    cbr_pkg::state_t state_reg, state_next;

    // input unpacking
    logic                          in_accept;
    cbr_pkg::func_t                in_func;
    logic [cbr_pkg::NODE_W-1:0]    in_node;
    logic [cbr_pkg::TIME_W-1:0]    in_start;
    logic [cbr_pkg::ACC_W-1:0]     in_dur;
    logic                          in_busy;
    logic [cbr_pkg::TIME_W-1:0]    in_now;

    // captured item
    logic [cbr_pkg::NODE_W-1:0]    idx_reg;
    logic [cbr_pkg::ACC_W-1:0]     dur_reg;
    logic                          busy_req_reg;
    logic [cbr_pkg::TIME_W-1:0]    now_reg;
    logic                          before_reg;
    logic [cbr_pkg::TIME_W-1:0]    cut_reg;
    logic [cbr_pkg::ACC_W-1:0]     dur_eff_reg;

    // block state kept in flops
    logic [cbr_pkg::TIME_W-1:0]    boundary_reg;
    logic [cbr_pkg::NODES-1:0]     seen_reg;
    logic [cbr_pkg::NODES-1:0]     has_avg_reg;
    logic [cbr_pkg::WMS_W-1:0]     wms_reg;
    logic [cbr_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [cbr_pkg::WNS_W-1:0]     wns_reg;

    // working registers
    logic [cbr_pkg::RATIO_W-1:0]   ratio_reg;
    logic [cbr_pkg::SUM_W-1:0]     sum_reg;
    logic [cbr_pkg::CNT_W-1:0]     cnt_reg;
    logic [cbr_pkg::RATIO_W-1:0]   res_ratio_reg;
    logic                          res_valid_reg;

    // output register
    logic                          out_valid_reg;
    logic [cbr_pkg::RATIO_W-1:0]   out_ratio_reg;
    logic                          out_flag_reg;

    // memories
    logic                          acc_we;
    logic [cbr_pkg::ACC_W-1:0]     acc_wdata;
    logic [cbr_pkg::ACC_W-1:0]     acc_rdata;
    logic                          avg_we;
    logic [cbr_pkg::RATIO_W-1:0]   avg_wdata;
    logic [cbr_pkg::RATIO_W-1:0]   avg_rdata;

    // datapath
    logic                          last_node;
    logic                          out_free;
    logic [cbr_pkg::ACC_W-1:0]     acc_cur;
    logic [cbr_pkg::ACC_W:0]       acc_sum;
    logic                          ratio_sat;
    logic [cbr_pkg::ALPHA_W-1:0]   alpha_eff;
    logic [cbr_pkg::WMS_W-1:0]     wms_eff;
    logic [cbr_pkg::WNS_W-1:0]     wns_calc;
    logic signed [cbr_pkg::RATIO_W:0]       ema_diff;
    logic signed [2*cbr_pkg::RATIO_W+1:0]   ema_prod;
    logic signed [2*cbr_pkg::RATIO_W+1:0]   ema_sum;
    logic [cbr_pkg::RATIO_W-1:0]   ema_val;

    cbr_pkg::div_req_t             div_req;
    cbr_pkg::div_rsp_t             div_rsp;

    assign in_func  = cbr_pkg::func_t'(s_axis_tuser);
    assign in_node  = s_axis_tdata[cbr_pkg::NODE_LSB +: cbr_pkg::NODE_W];
    assign in_start = s_axis_tdata[cbr_pkg::START_LSB +: cbr_pkg::TIME_W];
    assign in_dur   = s_axis_tdata[cbr_pkg::DUR_LSB +: cbr_pkg::ACC_W];
    assign in_busy  = s_axis_tdata[cbr_pkg::BUSY_LSB];
    assign in_now   = s_axis_tdata[cbr_pkg::NOW_LSB +: cbr_pkg::TIME_W];

    assign s_axis_tready = (state_reg == cbr_pkg::ST_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;

    assign last_node = (idx_reg == cbr_pkg::NODE_W'(cbr_pkg::NODES - 1));
    assign out_free = !out_valid_reg || m_axis_tready;

    // accumulator entries of nodes not seen since the last tick read as zero
    assign acc_cur = seen_reg[idx_reg] ? acc_rdata : '0;
    assign acc_sum = {1'b0, acc_cur} + {1'b0, dur_eff_reg};
    assign acc_wdata = acc_sum[cbr_pkg::ACC_W] ? {cbr_pkg::ACC_W{1'b1}}
                                               : acc_sum[cbr_pkg::ACC_W-1:0];

    // window length in ns, refreshed every cycle from the register
    assign wms_eff = (wms_reg == '0) ? cbr_pkg::WMS_W'(1) : wms_reg;
    assign wns_calc = cbr_pkg::WNS_W'(wms_eff) * cbr_pkg::WNS_W'(cbr_pkg::NS_PER_MS);

    // busy at least one full window saturates the ratio at one
    assign ratio_sat = (acc_rdata >= {{(cbr_pkg::ACC_W - cbr_pkg::WNS_W){1'b0}}, wns_reg});

    // ema as r + a * (avg - r), rounded to nearest
    assign alpha_eff = (alpha_reg > cbr_pkg::ALPHA_W'(cbr_pkg::ONE_Q16))
                       ? cbr_pkg::ALPHA_W'(cbr_pkg::ONE_Q16) : alpha_reg;
    assign ema_diff = $signed({1'b0, avg_rdata}) - $signed({1'b0, ratio_reg});
    assign ema_prod = $signed({1'b0, alpha_eff}) * ema_diff;
    assign ema_sum = $signed({3'b000, ratio_reg, 16'h0000}) + ema_prod
                     + $signed((2*cbr_pkg::RATIO_W+2)'(32768));
    assign ema_val = ema_sum[cbr_pkg::RATIO_W+15:16];
    assign avg_wdata = has_avg_reg[idx_reg] ? ema_val : ratio_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbr_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_func)
                        cbr_pkg::FN_EVENT:     state_next = cbr_pkg::ST_EV_RD;
                        cbr_pkg::FN_TICK:      state_next = cbr_pkg::ST_TK_RD;
                        cbr_pkg::FN_READ_NODE: state_next = cbr_pkg::ST_QR_RD;
                        cbr_pkg::FN_READ_MEAN: state_next = cbr_pkg::ST_MN_RD;
                        default:               state_next = cbr_pkg::ST_IDLE;
                    endcase
                end
            end
            cbr_pkg::ST_EV_RD:    state_next = cbr_pkg::ST_EV_WR;
            cbr_pkg::ST_EV_WR:    state_next = cbr_pkg::ST_RESP;
            cbr_pkg::ST_TK_RD:
            begin
                if (seen_reg[idx_reg])
                begin
                    state_next = cbr_pkg::ST_TK_CALC;
                end
                else if (last_node)
                begin
                    state_next = cbr_pkg::ST_TK_END;
                end
            end
            cbr_pkg::ST_TK_CALC:
            begin
                state_next = ratio_sat ? cbr_pkg::ST_TK_EMA : cbr_pkg::ST_TK_DIV;
            end
            cbr_pkg::ST_TK_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = cbr_pkg::ST_TK_EMA;
                end
            end
            cbr_pkg::ST_TK_EMA:
            begin
                state_next = last_node ? cbr_pkg::ST_TK_END : cbr_pkg::ST_TK_RD;
            end
            cbr_pkg::ST_TK_END:   state_next = cbr_pkg::ST_RESP;
            cbr_pkg::ST_QR_RD:    state_next = cbr_pkg::ST_QR_GET;
            cbr_pkg::ST_QR_GET:   state_next = cbr_pkg::ST_RESP;
            cbr_pkg::ST_MN_RD:    state_next = cbr_pkg::ST_MN_ACC;
            cbr_pkg::ST_MN_ACC:
            begin
                state_next = last_node ? cbr_pkg::ST_MN_START : cbr_pkg::ST_MN_RD;
            end
            cbr_pkg::ST_MN_START:
            begin
                state_next = (cnt_reg == '0) ? cbr_pkg::ST_RESP : cbr_pkg::ST_MN_DIV;
            end
            cbr_pkg::ST_MN_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = cbr_pkg::ST_RESP;
                end
            end
            cbr_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = cbr_pkg::ST_IDLE;
                end
            end
            default:              state_next = cbr_pkg::ST_IDLE;
        endcase
    end

    // state outputs: memory writes and divider requests
    always_comb
    begin
        acc_we = 1'b0;
        avg_we = 1'b0;
        div_req.start = 1'b0;
        div_req.steps = cbr_pkg::MEAN_STEPS;
        div_req.rem0 = '0;
        div_req.ext = sum_reg;
        div_req.divisor = cbr_pkg::WNS_W'(cnt_reg);
        case (state_reg)
            cbr_pkg::ST_EV_WR:
            begin
                // every event writes, so a seen entry always holds this window's sum
                acc_we = 1'b1;
            end
            cbr_pkg::ST_TK_CALC:
            begin
                // acc is below one window here, so it fits the remainder
                div_req.start = !ratio_sat;
                div_req.steps = cbr_pkg::TICK_STEPS;
                div_req.rem0 = acc_rdata[cbr_pkg::WNS_W-1:0];
                div_req.ext = '0;
                div_req.divisor = wns_reg;
            end
            cbr_pkg::ST_TK_EMA:
            begin
                avg_we = 1'b1;
            end
            cbr_pkg::ST_MN_START:
            begin
                div_req.start = (cnt_reg != '0);
            end
            default:
            begin
                acc_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbr_pkg::ST_IDLE;
            seen_reg      <= '0;
            has_avg_reg   <= '0;
            boundary_reg  <= '0;
            wms_reg       <= cbr_pkg::WMS_RESET;
            alpha_reg     <= cbr_pkg::ALPHA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cbr_pkg::cfg_idx_t'(cfg_addr))
                    cbr_pkg::REG_WINDOW_MS: wms_reg <= cfg_wdata[cbr_pkg::WMS_W-1:0];
                    cbr_pkg::REG_ALPHA:     alpha_reg <= cfg_wdata[cbr_pkg::ALPHA_W-1:0];
                    default:                wms_reg <= wms_reg;
                endcase
            end

            if (state_reg == cbr_pkg::ST_EV_WR)
            begin
                seen_reg[idx_reg] <= 1'b1;
            end
            if (state_reg == cbr_pkg::ST_TK_EMA)
            begin
                has_avg_reg[idx_reg] <= 1'b1;
            end
            if (state_reg == cbr_pkg::ST_TK_END)
            begin
                seen_reg     <= '0;
                boundary_reg <= now_reg;
            end

            // result register: load from the sequencer, drop on transfer
            if (state_reg == cbr_pkg::ST_RESP && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        wns_reg <= wns_calc;

        if (in_accept)
        begin
            idx_reg       <= (in_func == cbr_pkg::FN_TICK || in_func == cbr_pkg::FN_READ_MEAN)
                             ? '0 : in_node;
            dur_reg       <= in_dur;
            busy_req_reg  <= in_busy;
            now_reg       <= in_now;
            before_reg    <= (in_start < boundary_reg);
            cut_reg       <= boundary_reg - in_start;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            res_ratio_reg <= '0;
            res_valid_reg <= 1'b0;
        end

        case (state_reg)
            cbr_pkg::ST_EV_RD:
            begin
                // an idle interval adds nothing; drop the part before the last boundary
                if (!busy_req_reg)
                begin
                    dur_eff_reg <= '0;
                end
                else if (!before_reg)
                begin
                    dur_eff_reg <= dur_reg;
                end
                else if ({{(cbr_pkg::TIME_W - cbr_pkg::ACC_W){1'b0}}, dur_reg} > cut_reg)
                begin
                    dur_eff_reg <= dur_reg - cut_reg[cbr_pkg::ACC_W-1:0];
                end
                else
                begin
                    dur_eff_reg <= '0;
                end
            end
            cbr_pkg::ST_TK_RD:
            begin
                if (!seen_reg[idx_reg] && !last_node)
                begin
                    idx_reg <= idx_reg + cbr_pkg::NODE_W'(1);
                end
            end
            cbr_pkg::ST_TK_CALC:
            begin
                ratio_reg <= cbr_pkg::ONE_Q16;
            end
            cbr_pkg::ST_TK_DIV:
            begin
                if (div_rsp.done)
                begin
                    ratio_reg <= div_rsp.quot[cbr_pkg::RATIO_W-1:0];
                end
            end
            cbr_pkg::ST_TK_EMA:
            begin
                if (!last_node)
                begin
                    idx_reg <= idx_reg + cbr_pkg::NODE_W'(1);
                end
            end
            cbr_pkg::ST_QR_GET:
            begin
                res_ratio_reg <= has_avg_reg[idx_reg] ? avg_rdata : '0;
                res_valid_reg <= has_avg_reg[idx_reg];
            end
            cbr_pkg::ST_MN_ACC:
            begin
                if (has_avg_reg[idx_reg])
                begin
                    sum_reg <= sum_reg + cbr_pkg::SUM_W'(avg_rdata);
                    cnt_reg <= cnt_reg + cbr_pkg::CNT_W'(1);
                end
                if (!last_node)
                begin
                    idx_reg <= idx_reg + cbr_pkg::NODE_W'(1);
                end
            end
            cbr_pkg::ST_MN_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_ratio_reg <= div_rsp.quot[cbr_pkg::RATIO_W-1:0];
                    res_valid_reg <= 1'b1;
                end
            end
            default:
            begin
                dur_eff_reg <= dur_eff_reg;
            end
        endcase

        if (state_reg == cbr_pkg::ST_RESP && out_free)
        begin
            out_ratio_reg <= res_ratio_reg;
            out_flag_reg  <= res_valid_reg;
        end
    end

    // busy time per node, valid only where the seen flag is set
    cbr_ram #(
        .WIDTH (cbr_pkg::ACC_W),
        .DEPTH (cbr_pkg::NODES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (idx_reg),
        .wdata (acc_wdata),
        .raddr (idx_reg),
        .rdata (acc_rdata)
    );

    // averaged ratio per node, valid only where the average flag is set
    cbr_ram #(
        .WIDTH (cbr_pkg::RATIO_W),
        .DEPTH (cbr_pkg::NODES)
    ) u_avg_ram (
        .clk   (clk),
        .we    (avg_we),
        .waddr (idx_reg),
        .wdata (avg_wdata),
        .raddr (idx_reg),
        .rdata (avg_rdata)
    );

    cbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = cbr_pkg::OUT_DATA_W'(out_ratio_reg);
    assign m_axis_tuser = out_flag_reg;

    // a ratio never goes above one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[cbr_pkg::RATIO_W-1:0] <= cbr_pkg::ONE_Q16))
        else $error("result ratio above one");

    // a result without a value carries a zero ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[cbr_pkg::RATIO_W-1:0] == '0))
        else $error("nonzero ratio on a result without a value");

    // one item at a time: no new transfer right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // divider results arrive only while the sequencer waits for them
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == cbr_pkg::ST_TK_DIV || state_reg == cbr_pkg::ST_MN_DIV))
        else $error("divider finished outside a divide wait");

    // a divide is never started while another one is still running
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_req.start)
        else $error("back to back divider starts");

endmodule
